// ----- design/bsp_pkg.sv -----
package bsp_pkg;

  localparam int unsigned STORE_BYTES_DEF = 1024;
  localparam int unsigned CHUNK_BITS_DEF  = 32;

  localparam int unsigned POS_W  = 14;
  localparam int unsigned BINT_W = 32;
  localparam int unsigned BIDX_W = $clog2(BINT_W);
  localparam int unsigned BLEN_W = $clog2(BINT_W + 1);

  localparam logic [POS_W-1:0] CAP_RESET = 14'd8192;

  localparam logic [2:0] OP_APPEND   = 3'd0;
  localparam logic [2:0] OP_BOUNDED  = 3'd1;
  localparam logic [2:0] OP_REWIND   = 3'd2;
  localparam logic [2:0] OP_OVERFLOW = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [5:0]  length_bits;
    logic [31:0] value_max;
    logic [13:0] mark_position;
    logic        mark_overflow;
    logic [9:0]  byte_index;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] bit_count;
    logic [10:0] byte_count;
    logic        overflow;
  } result_t;

  // bounded-int encoder result: bits to append, how many, and room required
  typedef struct packed {
    logic              done;
    logic [BINT_W-1:0] bits;
    logic [BLEN_W-1:0] length;
    logic [BLEN_W-1:0] need;
  } bint_res_t;

endpackage

// ----- design/bsp_bint.sv -----
module bsp_bint (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bsp_pkg::BINT_W-1:0]  value,
  input  logic [bsp_pkg::BINT_W-1:0]  value_max,
  output bsp_pkg::bint_res_t          res
);

  logic                         active;
  logic                         stopped;
  logic [bsp_pkg::BIDX_W-1:0]   idx;
  logic [bsp_pkg::BINT_W-1:0]   sum;
  logic [bsp_pkg::BINT_W-1:0]   val;
  logic [bsp_pkg::BINT_W-1:0]   vmax;
  logic [bsp_pkg::BINT_W-1:0]   vm1;
  logic [bsp_pkg::BINT_W-1:0]   cand;
  logic                         take;
  logic [bsp_pkg::BLEN_W-1:0]   idx_p1;

  // sum only holds bits below idx, so sum + weight is an OR
  assign cand   = sum | (bsp_pkg::BINT_W'(1) << idx);
  assign take   = !stopped && (cand < vmax);
  assign idx_p1 = bsp_pkg::BLEN_W'(idx) + bsp_pkg::BLEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        active     <= 1'b1;
        stopped    <= 1'b0;
        idx        <= '0;
        sum        <= '0;
        val        <= value;
        vmax       <= value_max;
        vm1        <= (value_max <= bsp_pkg::BINT_W'(1)) ? '0
                                                          : value_max - bsp_pkg::BINT_W'(1);
        res.bits   <= '0;
        res.length <= '0;
        res.need   <= '0;
      end else if (active) begin
        if (take) begin
          if (val[idx]) begin
            sum           <= cand;
            res.bits[idx] <= 1'b1;
          end
          res.length <= idx_p1;
        end else begin
          stopped <= 1'b1;
        end
        // ceil(log2(max)) is the bit length of max-1
        if (vm1[idx]) begin
          res.need <= idx_p1;
        end
        if (idx == bsp_pkg::BIDX_W'(bsp_pkg::BINT_W - 1)) begin
          active   <= 1'b0;
          res.done <= 1'b1;
        end
        idx <= idx + bsp_pkg::BIDX_W'(1);
      end
    end
  end

endmodule

// ----- design/bitstream_packer.sv -----
// LSB-first bit packer over a byte store of STORE_BYTES entries. Raise start
// with a command in item while busy is low; exactly one result follows, shown
// on result for a single cycle with done high, and the receiver cannot stall
// it, so capture it on that cycle. An append (op 0) that fits writes
// ceil((p%8 + n)/8) store bytes, p the bit count and n the appended length:
// one read-modify-write of the partial byte, then one store write per byte
// on the single write port; an append that overflows goes straight to the
// result. Bounded int (op 1) first runs the bit-serial encoder that walks the
// 32 weights. Rewind, force overflow, read and unused ops go straight to the
// result. No clearing pass runs after reset: bytes at or beyond the bit count
// read as zero, so rewind costs no store sweep. The user must write
// capacity_bits via cfg_we/cfg_wdata only while idle; it is not enforced.
module bitstream_packer #(
  parameter int unsigned STORE_BYTES = bsp_pkg::STORE_BYTES_DEF,
  parameter int unsigned CHUNK_BITS  = bsp_pkg::CHUNK_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  bsp_pkg::item_t            item,
  output logic                      busy,
  output logic                      done,
  output bsp_pkg::result_t          result,
  input  logic                      cfg_we,
  input  logic [bsp_pkg::POS_W-1:0] cfg_wdata
);

  localparam int unsigned STORE_BITS = STORE_BYTES * 8;
  localparam int unsigned ADDR_W     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned DATA_W     = (CHUNK_BITS > bsp_pkg::BINT_W) ? CHUNK_BITS
                                                                       : bsp_pkg::BINT_W;
  localparam int unsigned SH_W       = DATA_W + 8;
  localparam int unsigned LEN_W      = $clog2(DATA_W + 1);
  localparam int unsigned NB_W       = $clog2((DATA_W + 14) / 8 + 1);
  localparam int unsigned POS_W      = bsp_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BINT  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]  pos;
  logic              ovf;
  logic [POS_W-1:0]  capacity;
  logic [POS_W-1:0]  limit;
  logic [SH_W-1:0]   sh;
  logic [LEN_W-1:0]  len_q;
  logic [NB_W-1:0]   nb;
  logic [NB_W-1:0]   wr_cnt;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        rd_q;
  logic [7:0]        keep_q;
  logic [7:0]        mem [STORE_BYTES];

  logic [ADDR_W-1:0] raddr;
  logic              mem_we;
  logic [7:0]        wdata;
  logic [7:0]        low_mask;
  logic [2:0]        off;
  logic [10:0]       pos_byte;
  logic [14:0]       pos_p7;

  logic [LEN_W-1:0]  app_len;
  logic [DATA_W-1:0] value_ext;
  logic [DATA_W-1:0] app_data;
  logic              app_fits;
  logic              bint_fits;
  logic [7:0]        keep_next;
  logic              accept;

  bsp_pkg::bint_res_t bint_res;

  bsp_bint u_bint (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && item.op == bsp_pkg::OP_BOUNDED),
    .value     (item.value),
    .value_max (item.value_max),
    .res       (bint_res)
  );

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_RESP);
  assign off      = pos[2:0];
  assign pos_byte = pos[POS_W-1:3];
  assign pos_p7   = {1'b0, pos} + 15'd7;
  assign low_mask = (8'h01 << off) - 8'h01;
  assign limit    = (32'(capacity) < STORE_BITS) ? capacity : POS_W'(STORE_BITS);

  assign app_len   = (32'(item.length_bits) > CHUNK_BITS) ? LEN_W'(CHUNK_BITS)
                                                          : LEN_W'(item.length_bits);
  assign value_ext = DATA_W'(item.value);
  assign app_fits  = ({1'b0, pos} + 15'(app_len)) <= {1'b0, limit};
  assign bint_fits = ({1'b0, pos} + 15'(bint_res.need)) <= {1'b0, limit};

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      app_data[i] = value_ext[i] && (i < 32'(app_len));
    end
  end

  // bytes at or past the bit count are zero by definition, whatever the store holds
  always_comb begin
    if ({1'b0, item.byte_index} < pos_byte) begin
      keep_next = 8'hFF;
    end else if ({1'b0, item.byte_index} == pos_byte) begin
      keep_next = low_mask;
    end else begin
      keep_next = 8'h00;
    end
  end

  assign raddr  = (state == S_IDLE && item.op == bsp_pkg::OP_READ) ?
                  ADDR_W'(item.byte_index) : ADDR_W'(pos_byte);
  assign mem_we = (state == S_WRITE);
  assign wdata  = (wr_cnt == '0) ? ((rd_q & low_mask) | sh[7:0]) : sh[7:0];

  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
    if (mem_we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (item.op == bsp_pkg::OP_BOUNDED) begin
            state_next = S_BINT;
          end else if (item.op == bsp_pkg::OP_APPEND && app_fits &&
                       8'(off) + 8'(app_len) != 8'd0) begin
            state_next = S_WRITE;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_BINT: begin
        if (bint_res.done) begin
          state_next = (bint_fits && bint_res.length != '0) ? S_WRITE : S_RESP;
        end
      end
      S_WRITE: begin
        if (wr_cnt == nb - NB_W'(1)) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pos      <= '0;
      ovf      <= 1'b0;
      capacity <= bsp_pkg::CAP_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            keep_q <= (item.op == bsp_pkg::OP_READ) ? keep_next : 8'h00;
            wr_cnt <= '0;
            wr_addr <= ADDR_W'(pos_byte);
            unique case (item.op)
              bsp_pkg::OP_APPEND: begin
                if (app_fits) begin
                  sh    <= SH_W'(app_data) << off;
                  len_q <= app_len;
                  nb    <= NB_W'((8'(off) + 8'(app_len) + 8'd7) >> 3);
                end else begin
                  ovf <= 1'b1;
                end
              end
              bsp_pkg::OP_REWIND: begin
                // a mark past the current position is ignored
                if (item.mark_position <= pos) begin
                  pos <= item.mark_position;
                  ovf <= item.mark_overflow;
                end
              end
              bsp_pkg::OP_OVERFLOW: begin
                ovf <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_BINT: begin
          if (bint_res.done) begin
            if (bint_fits) begin
              sh    <= SH_W'(bint_res.bits) << off;
              len_q <= LEN_W'(bint_res.length);
              nb    <= NB_W'((8'(off) + 8'(bint_res.length) + 8'd7) >> 3);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_WRITE: begin
          sh      <= sh >> 8;
          wr_cnt  <= wr_cnt + NB_W'(1);
          wr_addr <= wr_addr + ADDR_W'(1);
          if (wr_cnt == nb - NB_W'(1)) begin
            pos <= POS_W'({1'b0, pos} + 15'(len_q));
          end
        end
        S_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign result.read_data  = rd_q & keep_q;
  assign result.bit_count  = pos;
  assign result.byte_count = pos_p7[13:3];
  assign result.overflow   = ovf;

  a_store_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) <= STORE_BITS)
    else $error("bit position beyond store");

  a_wr_addr: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> 32'(wr_addr) < STORE_BYTES)
    else $error("store write out of range");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results for one transaction");

  a_pos_change: assert property (@(posedge clk) disable iff (rst)
    (pos != $past(pos)) |-> ($past(state) == S_WRITE || $past(state) == S_IDLE))
    else $error("bit position changed outside a write or rewind");

  a_bint_done: assert property (@(posedge clk) disable iff (rst)
    bint_res.done |-> state == S_BINT)
    else $error("encoder finished with no bounded int pending");

endmodule
